>>> sv/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
`default_nettype none

package wsfd_pkg;

    localparam int LEN_BITS = 24;
    localparam int KEY_BITS = 32;
    localparam int CLOSE_BITS = 16;
    localparam int HCNT_BITS = 4;

    localparam logic [3:0]  OPC_CLOSE = 4'h8;
    localparam logic [6:0]  LEN7_EXT16 = 7'd126;
    localparam logic [6:0]  LEN7_EXT64 = 7'd127;
    localparam logic [HCNT_BITS-1:0] EXT16_BYTES = 4'd2;
    localparam logic [HCNT_BITS-1:0] EXT64_BYTES = 4'd8;
    localparam logic [HCNT_BITS-1:0] KEY_BYTES = 4'd4;
    localparam logic [LEN_BITS-1:0] MAX_PAYLOAD_RST = {LEN_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  byte_valid;
        logic                  frame_end;
        logic                  fin_flag;
        logic [3:0]            frame_opcode;
        logic                  was_masked;
        logic [CLOSE_BITS-1:0] close_code;
        logic                  close_valid;
        logic [LEN_BITS-1:0]   payload_length;
        logic                  status;
    } t_result;

    // Handshake between the input register and the parser.
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_in_item;

endpackage

`default_nettype wire

>>> sv/websocket_frame_decoder_top.sv
// Top level of the WebSocket frame decoder.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_data_byte
//  output    out        o_out_valid / i_out_stall  o_out_byte .. o_status
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (max_payload)
//
// One byte per cycle sustained while the output is not stalled; an accepted byte is
// held in the input register, and the parser step writes its result to the output register.
// Header bytes and close code bytes usually produce no result.
// Synchronous active-low reset returns the parser to the first header byte,
// clears the sticky error and sets max_payload to all ones.
// An output stall holds the result register and backs up into the input.
`default_nettype none

module websocket_frame_decoder_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [7:0]                          o_out_byte,
    output logic                                o_byte_valid,
    output logic                                o_frame_end,
    output logic                                o_fin_flag,
    output logic [3:0]                          o_frame_opcode,
    output logic                                o_was_masked,
    output logic [wsfd_pkg::CLOSE_BITS-1:0]     o_close_code,
    output logic                                o_close_valid,
    output logic [wsfd_pkg::LEN_BITS-1:0]       o_payload_length,
    output logic                                o_status,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [wsfd_pkg::LEN_BITS-1:0]       i_cfg_data
);
    import wsfd_pkg::*;

    logic [LEN_BITS-1:0] r_max_payload;
    t_in_item            item;
    logic                adv;
    logic                res_vld;
    t_result             res;
    t_result             out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_payload <= i_cfg_data;
        end
    end

    wsfd_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .o_in_stall  (o_in_stall),
        .i_adv       (adv),
        .o_item      (item)
    );

    wsfd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_item        (item),
        .i_max_payload (r_max_payload),
        .o_res_vld     (res_vld),
        .o_res         (res)
    );

    wsfd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_vld   (res_vld),
        .i_res       (res),
        .i_item_vld  (item.vld),
        .i_out_stall (i_out_stall),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_out_byte       = out_res.out_byte;
    assign o_byte_valid     = out_res.byte_valid;
    assign o_frame_end      = out_res.frame_end;
    assign o_fin_flag       = out_res.fin_flag;
    assign o_frame_opcode   = out_res.frame_opcode;
    assign o_was_masked     = out_res.was_masked;
    assign o_close_code     = out_res.close_code;
    assign o_close_valid    = out_res.close_valid;
    assign o_payload_length = out_res.payload_length;
    assign o_status         = out_res.status;

endmodule

`default_nettype wire

>>> sv/wsfd_in_reg.sv
// Input register for the raw byte stream.
`default_nettype none

module wsfd_in_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire [7:0]            i_data_byte,
    output logic                 o_in_stall,
    input  wire                  i_adv,
    output wsfd_pkg::t_in_item   o_item
);
    import wsfd_pkg::*;

    logic       r_vld;
    logic [7:0] r_data;
    logic       load;

    assign load       = !r_vld || i_adv;
    assign o_in_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_data <= i_data_byte;
        end
    end

    assign o_item.vld  = r_vld;
    assign o_item.data = r_data;

endmodule

`default_nettype wire

>>> sv/wsfd_parser.sv
// Frame parser: header state machine, length check, unmasking, close code.
`default_nettype none

module wsfd_parser (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_adv,
    input  wire wsfd_pkg::t_in_item         i_item,
    input  wire [wsfd_pkg::LEN_BITS-1:0]    i_max_payload,
    output logic                            o_res_vld,
    output wsfd_pkg::t_result               o_res
);
    import wsfd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [HCNT_BITS-1:0]  r_hcnt, n_hcnt;
    logic                  r_fin, n_fin;
    logic [3:0]            r_opc, n_opc;
    logic                  r_mask, n_mask;
    logic [LEN_BITS-1:0]   r_len, n_len;
    logic                  r_ovf, n_ovf;    // some length bit above LEN_BITS was set
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [LEN_BITS-1:0]   r_pcnt, n_pcnt;
    logic [CLOSE_BITS-1:0] r_close, n_close;
    logic                  r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_hcnt  <= '0;
            r_fin   <= 1'b0;
            r_opc   <= '0;
            r_mask  <= 1'b0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_key   <= '0;
            r_pcnt  <= '0;
            r_close <= '0;
            r_err   <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_fin   <= n_fin;
            r_opc   <= n_opc;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_key   <= n_key;
            r_pcnt  <= n_pcnt;
            r_close <= n_close;
            r_err   <= n_err;
        end
    end

    always_comb begin
        logic [7:0] b;
        logic [7:0] plain;
        logic [7:0] key_b;
        logic       do_ld;
        logic       do_sp;
        logic       last;
        logic       e_vld;
        logic [7:0] e_byte;
        logic       e_bvld;
        logic       e_end;
        logic       cv;

        b       = i_item.data;
        plain   = '0;
        key_b   = '0;
        do_ld   = 1'b0;
        do_sp   = 1'b0;
        last    = 1'b0;
        e_vld   = 1'b0;
        e_byte  = '0;
        e_bvld  = 1'b0;
        e_end   = 1'b0;

        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_fin   = r_fin;
        n_opc   = r_opc;
        n_mask  = r_mask;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_key   = r_key;
        n_pcnt  = r_pcnt;
        n_close = r_close;
        n_err   = r_err;

        if (r_err) begin
            e_vld = 1'b1;
        end else begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_mask = b[7];
                    n_hcnt = '0;
                    if (b[6:0] == LEN7_EXT16) begin
                        n_phase = PH_EXT16;
                    end else if (b[6:0] == LEN7_EXT64) begin
                        n_phase = PH_EXT64;
                    end else begin
                        n_len = LEN_BITS'(b[6:0]);
                        do_ld = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    n_len  = {r_len[LEN_BITS-9:0], b};
                    n_ovf  = r_ovf || (r_len[LEN_BITS-1 -: 8] != 8'd0);
                    n_hcnt = r_hcnt + 1'b1;
                    if (n_hcnt == ((r_phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
                        do_ld = 1'b1;
                    end
                end
                PH_MASK: begin
                    n_key  = {r_key[KEY_BITS-9:0], b};
                    n_hcnt = r_hcnt + 1'b1;
                    if (n_hcnt == KEY_BYTES) begin
                        do_sp = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    unique case (r_pcnt[1:0])
                        2'd0:    key_b = r_key[31:24];
                        2'd1:    key_b = r_key[23:16];
                        2'd2:    key_b = r_key[15:8];
                        default: key_b = r_key[7:0];
                    endcase
                    plain  = b ^ key_b;
                    n_pcnt = r_pcnt + 1'b1;
                    last   = (n_pcnt == r_len);
                    if (last) begin
                        n_phase = PH_HDR0;
                    end
                    // first two bytes of a close frame carry the close code
                    if (r_opc == OPC_CLOSE && r_len >= LEN_BITS'(2) &&
                        r_pcnt < LEN_BITS'(2)) begin
                        n_close = {r_close[7:0], plain};
                        e_vld   = last;
                        e_end   = last;
                    end else begin
                        e_vld  = 1'b1;
                        e_byte = plain;
                        e_bvld = 1'b1;
                        e_end  = last;
                    end
                end
                default: begin
                    n_fin   = b[7];
                    n_opc   = b[3:0];
                    n_mask  = 1'b0;
                    n_len   = '0;
                    n_ovf   = 1'b0;
                    n_key   = '0;
                    n_pcnt  = '0;
                    n_close = '0;
                    n_hcnt  = '0;
                    if (b[6:4] != 3'd0) begin
                        n_err   = 1'b1;
                        n_phase = PH_ERROR;
                        e_vld   = 1'b1;
                    end else begin
                        n_phase = PH_HDR1;
                    end
                end
            endcase

            if (do_ld) begin
                if (n_ovf || n_len > i_max_payload) begin
                    n_err   = 1'b1;
                    n_phase = PH_ERROR;
                    e_vld   = 1'b1;
                end else if (n_mask) begin
                    n_phase = PH_MASK;
                    n_hcnt  = '0;
                end else begin
                    do_sp = 1'b1;
                end
            end

            if (do_sp) begin
                if (n_len == '0) begin
                    n_phase = PH_HDR0;
                    e_vld   = 1'b1;
                    e_end   = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end

        cv = (n_opc == OPC_CLOSE) && (n_len >= LEN_BITS'(2)) && (n_pcnt >= LEN_BITS'(2));

        o_res_vld              = e_vld;
        o_res.out_byte         = e_bvld ? e_byte : 8'd0;
        o_res.byte_valid       = e_bvld;
        o_res.frame_end        = e_end;
        o_res.fin_flag         = n_fin;
        o_res.frame_opcode     = n_opc;
        o_res.was_masked       = n_mask;
        o_res.close_code       = cv ? n_close : '0;
        o_res.close_valid      = cv;
        o_res.payload_length   = n_len;
        o_res.status           = n_err;
    end

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("error flag cleared without reset");

    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_phase == PH_ERROR))
        else $error("error flag set outside error phase");

    a_pcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_pcnt < r_len))
        else $error("payload count ran past frame length");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res_vld && o_res.byte_valid) |-> !o_res.status)
        else $error("payload byte emitted while in error");
`endif

endmodule

`default_nettype wire

>>> sv/wsfd_out_reg.sv
// Result register on the output channel.
`default_nettype none

module wsfd_out_reg (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_res_vld,
    input  wire wsfd_pkg::t_result  i_res,
    input  wire                     i_item_vld,
    input  wire                     i_out_stall,
    output logic                    o_adv,
    output logic                    o_out_valid,
    output wsfd_pkg::t_result       o_res
);
    import wsfd_pkg::*;

    logic    r_vld;
    t_result r_res;

    // parser steps when an input byte is held and the result slot is free or being drained
    assign o_adv = i_item_vld && (!r_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_adv) begin
            r_vld <= i_res_vld;
        end else if (!i_out_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_res_vld) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_vld;
    assign o_res       = r_res;

endmodule

`default_nettype wire

>>> tb/websocket_frame_decoder_top_test.sv
// Self-checking testbench for the WebSocket frame decoder top level.
`timescale 1ns / 1ps

module websocket_frame_decoder_top_test;
    import wsfd_pkg::*;

    localparam int STALL_PCT = 10;
    localparam int GAP_PCT = 10;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_BYTES = 200;
    localparam logic [LEN_BITS-1:0] MAX_LEN_ALL = {LEN_BITS{1'b1}};

    typedef struct {
        logic [7:0] data;
        bit         typed;
        t_result    res;
    } t_row;

    bit                         i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [7:0]                 i_data_byte;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [7:0]                 o_out_byte;
    logic                       o_byte_valid;
    logic                       o_frame_end;
    logic                       o_fin_flag;
    logic [3:0]                 o_frame_opcode;
    logic                       o_was_masked;
    logic [CLOSE_BITS-1:0]      o_close_code;
    logic                       o_close_valid;
    logic [LEN_BITS-1:0]        o_payload_length;
    logic                       o_status;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [LEN_BITS-1:0]        i_cfg_data;

    // parser state mirrored by the predictor
    t_phase                     st_phase;
    logic [HCNT_BITS-1:0]       st_hcnt;
    logic                       st_fin;
    logic [3:0]                 st_opc;
    logic                       st_mask;
    logic [63:0]                st_len;
    logic [KEY_BITS-1:0]        st_key;
    logic [LEN_BITS-1:0]        st_count;
    logic [CLOSE_BITS-1:0]      st_close;
    logic                       st_err;
    logic [LEN_BITS-1:0]        max_len;

    t_result                    decoded_q[$];
    int unsigned                mismatches;
    int unsigned                bytes_sent;
    bit                         calm;

    websocket_frame_decoder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_frame_end      (o_frame_end),
        .o_fin_flag       (o_fin_flag),
        .o_frame_opcode   (o_frame_opcode),
        .o_was_masked     (o_was_masked),
        .o_close_code     (o_close_code),
        .o_close_valid    (o_close_valid),
        .o_payload_length (o_payload_length),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result mkres(logic [7:0] ob, bit bv, bit fe, bit fin, logic [3:0] op,
                                      bit mk, logic [15:0] cc, bit cv, logic [23:0] ln, bit st);
        t_result r;
        r.out_byte = ob;
        r.byte_valid = bv;
        r.frame_end = fe;
        r.fin_flag = fin;
        r.frame_opcode = op;
        r.was_masked = mk;
        r.close_code = cc;
        r.close_valid = cv;
        r.payload_length = ln;
        r.status = st;
        return r;
    endfunction

    function automatic void reset_parser();
        st_phase = PH_HDR0;
        st_hcnt = '0;
        st_fin = 1'b0;
        st_opc = '0;
        st_mask = 1'b0;
        st_len = '0;
        st_key = '0;
        st_count = '0;
        st_close = '0;
        st_err = 1'b0;
        max_len = MAX_PAYLOAD_RST;
    endfunction

    // result built from the latched header state
    function automatic t_result frame_result(logic [7:0] b, bit vld, bit fe);
        bit cv;
        cv = st_opc == OPC_CLOSE && st_len >= 2 && st_count >= 2;
        return mkres(vld ? b : 8'h00, vld, fe, st_fin, st_opc, st_mask,
                     cv ? st_close : 16'h0000, cv, st_len[LEN_BITS-1:0], st_err);
    endfunction

    function automatic bit start_payload(output t_result r);
        r = '0;
        if (st_len == 0) begin
            st_phase = PH_HDR0;
            r = frame_result(8'h00, 1'b0, 1'b1);
            return 1'b1;
        end
        st_phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic bit finish_length(output t_result r);
        r = '0;
        if (st_len > 64'(max_len) || st_len[63:LEN_BITS] != '0) begin
            st_err = 1'b1;
            st_phase = PH_ERROR;
            r = frame_result(8'h00, 1'b0, 1'b0);
            return 1'b1;
        end
        if (st_mask) begin
            st_phase = PH_MASK;
            st_hcnt = '0;
            return 1'b0;
        end
        return start_payload(r);
    endfunction

    // one raw byte through the parser; returns 1 when it yields a result
    function automatic bit decode_byte(input logic [7:0] b, output t_result r);
        logic [LEN_BITS-1:0] idx;
        logic [7:0]          plain;
        bit                  last;
        r = '0;
        if (st_err) begin
            r = frame_result(8'h00, 1'b0, 1'b0);
            return 1'b1;
        end
        case (st_phase)
            PH_HDR1: begin
                st_mask = b[7];
                st_hcnt = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    st_phase = PH_EXT16;
                    return 1'b0;
                end
                if (b[6:0] == LEN7_EXT64) begin
                    st_phase = PH_EXT64;
                    return 1'b0;
                end
                st_len = 64'(b[6:0]);
                return finish_length(r);
            end
            PH_EXT16, PH_EXT64: begin
                st_len = {st_len[55:0], b};
                st_hcnt = st_hcnt + 1'b1;
                if (st_hcnt == (st_phase == PH_EXT16 ? EXT16_BYTES : EXT64_BYTES))
                    return finish_length(r);
                return 1'b0;
            end
            PH_MASK: begin
                st_key = {st_key[23:0], b};
                st_hcnt = st_hcnt + 1'b1;
                if (st_hcnt == KEY_BYTES)
                    return start_payload(r);
                return 1'b0;
            end
            PH_PAYLOAD: begin
                plain = b ^ st_key[8 * (3 - int'(st_count[1:0])) +: 8];
                idx = st_count;
                st_count = st_count + 1'b1;
                last = 64'(st_count) == st_len;
                if (last)
                    st_phase = PH_HDR0;
                // close code bytes are swallowed
                if (st_opc == OPC_CLOSE && st_len >= 2 && idx < 2) begin
                    st_close = {st_close[7:0], plain};
                    if (last)
                        r = frame_result(8'h00, 1'b0, 1'b1);
                    return last;
                end
                r = frame_result(plain, 1'b1, last);
                return 1'b1;
            end
            default: begin
                st_fin = b[7];
                st_opc = b[3:0];
                st_mask = 1'b0;
                st_len = '0;
                st_key = '0;
                st_count = '0;
                st_close = '0;
                st_hcnt = '0;
                if (b[6:4] != 3'b000) begin
                    st_err = 1'b1;
                    st_phase = PH_ERROR;
                    r = frame_result(8'h00, 1'b0, 1'b0);
                    return 1'b1;
                end
                st_phase = PH_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    // entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_result typed_res = '0);
        t_result r;
        bit      has;
        if (!calm && $urandom_range(0, 99) < GAP_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        has = decode_byte(b, r);
        if (typed)
            decoded_q = {decoded_q, typed_res};
        else if (has)
            decoded_q = {decoded_q, r};
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain(input int extra);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (decoded_q.size() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_max(input logic [LEN_BITS-1:0] v);
        drain(4);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        max_len = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // well-formed frame whose length respects the current max_payload
    task automatic send_frame();
        logic [3:0]  opc;
        logic [63:0] len64;
        bit          fin;
        bit          msk;
        int unsigned cap;
        int unsigned len;
        int unsigned form;
        int unsigned pick;
        opc = ($urandom_range(0, 3) == 0) ? OPC_CLOSE : 4'($urandom_range(0, 15));
        fin = 1'($urandom_range(0, 1));
        msk = 1'($urandom_range(0, 1));
        cap = (max_len < 300) ? max_len : 300;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = 0;
        else if (pick < 25)
            len = $urandom_range(0, (cap < 3) ? cap : 3);
        else if (pick < 32)
            len = cap;
        else if (pick < 90)
            len = $urandom_range(0, (cap < 24) ? cap : 24);
        else
            len = $urandom_range(0, cap);
        len64 = 64'(len);
        form = $urandom_range(0, 9);
        if (len > 125 && form < 6)
            form = 6;
        send_byte({fin, 3'b000, opc});
        if (form < 6) begin
            send_byte({msk, len64[6:0]});
        end else if (form < 8) begin
            send_byte({msk, LEN7_EXT16});
            send_byte(len64[15:8]);
            send_byte(len64[7:0]);
        end else begin
            send_byte({msk, LEN7_EXT64});
            for (int i = 7; i >= 0; i--)
                send_byte(len64[8 * i +: 8]);
        end
        if (msk)
            repeat (4) send_byte(8'($urandom_range(0, 255)));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < STALL_PCT);
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = mkres(o_out_byte, o_byte_valid, o_frame_end, o_fin_flag, o_frame_opcode,
                        o_was_masked, o_close_code, o_close_valid, o_payload_length, o_status);
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                check_field("out_byte", want.out_byte, got.out_byte);
                check_field("byte_valid", want.byte_valid, got.byte_valid);
                check_field("frame_end", want.frame_end, got.frame_end);
                check_field("fin_flag", want.fin_flag, got.fin_flag);
                check_field("frame_opcode", want.frame_opcode, got.frame_opcode);
                check_field("was_masked", want.was_masked, got.was_masked);
                check_field("close_code", want.close_code, got.close_code);
                check_field("close_valid", want.close_valid, got.close_valid);
                check_field("payload_length", want.payload_length, got.payload_length);
                check_field("status", want.status, got.status);
            end
        end
    end

    // cycles without any transaction on any channel
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        t_row                rows[$];
        logic [LEN_BITS-1:0] settings[7];
        logic [63:0]         big_len;
        int unsigned         phase_start;
        bit                  paused;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_data_byte <= 8'h00;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        mismatches = 0;
        bytes_sent = 0;
        calm = 1'b0;
        paused = 1'b0;
        reset_parser();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        rows = '{
            // empty text frame
            '{8'h81, 1'b0, '0},
            '{8'h00, 1'b1, mkres(8'h00, 0, 1, 1, 4'h1, 0, 16'h0, 0, 24'd0, 0)},
            // one masked byte, all-ones key, non-final frame with opcode 15
            '{8'h0F, 1'b0, '0},
            '{8'h81, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h5A, 1'b1, mkres(8'hA5, 1, 1, 0, 4'hF, 1, 16'h0, 0, 24'd1, 0)},
            // close frame carrying only its code
            '{{4'h8, OPC_CLOSE}, 1'b0, '0},
            '{8'h02, 1'b0, '0},
            '{8'h03, 1'b0, '0},
            '{8'hE8, 1'b1, mkres(8'h00, 0, 1, 1, OPC_CLOSE, 0, 16'h03E8, 1, 24'd2, 0)},
            // empty frame behind a 64-bit length field
            '{8'h00, 1'b0, '0},
            '{{1'b0, LEN7_EXT64}, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b1, mkres(8'h00, 0, 1, 0, 4'h0, 0, 16'h0, 0, 24'd0, 0)}
        };
        foreach (rows[i])
            send_byte(rows[i].data, rows[i].typed, rows[i].res);

        settings = '{24'd0, 24'd1, 24'd2, MAX_LEN_ALL,
                     LEN_BITS'($urandom_range(301, 24'hFFFFFE)), 24'd300,
                     LEN_BITS'($urandom_range(3, 100))};
        foreach (settings[i]) begin
            write_max(settings[i]);
            calm = (i == 5);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_frame();
                if (i == 3 && !paused && bytes_sent - phase_start > PHASE_BYTES / 2) begin
                    drain(0);
                    paused = 1'b1;
                end
            end
            calm = 1'b0;
        end

        // sticky error last: nothing but reset clears it
        case ($urandom_range(0, 2))
            0: send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                          4'($urandom_range(0, 15))});
            1: begin
                send_byte(8'h81);
                send_byte({1'($urandom_range(0, 1)), 7'(max_len + 1'b1)});
            end
            default: begin
                big_len = {$urandom, $urandom};
                big_len[$urandom_range(LEN_BITS, 63)] = 1'b1;
                send_byte(8'h82);
                send_byte({1'($urandom_range(0, 1)), LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(big_len[8 * i +: 8]);
            end
        endcase
        repeat (20) send_byte(8'($urandom_range(0, 255)));

        drain(10);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
